// File: src/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;

  localparam logic       CMD_WRITE    = 1'b0;
  localparam logic       CMD_READ     = 1'b1;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  // One cursor operation per accepted write beat
  typedef struct packed {
    logic put_char;
    logic new_line;
  } cur_op_t;

endpackage

// File: src/tcw_screen_ram.sv
module tcw_screen_ram #(
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/tcw_cursor.sv
module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int ROW_W   = $clog2(ROWS),
  parameter int COL_W   = $clog2(COLUMNS),
  parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_pkg::cur_op_t    op,
  input  logic [ROW_W-1:0]    rd_row,
  input  logic [COL_W-1:0]    rd_col,
  input  logic                rd_in_range,
  output logic [ADDR_W-1:0]   rd_addr,
  output logic                rd_hit,
  output logic [ADDR_W-1:0]   wr_addr,
  output logic [ROW_W-1:0]    cur_row,
  output logic [COL_W-1:0]    cur_col,
  output logic [ROW_W-1:0]    row_nxt,
  output logic [COL_W-1:0]    col_nxt,
  output logic                scroll_nxt
);

  localparam int FILL_W = $clog2(COLUMNS + 1);

  // Screen rows live in a ring: top_r is the physical row shown as row 0.
  // fill_r counts the leading written cells of each physical row; the rest read blank.
  logic [ROW_W-1:0]  row_r, phys_r, top_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  phys_nxt, top_nxt;
  logic [FILL_W-1:0] fill_r [ROWS];
  logic [FILL_W-1:0] col_inc;
  logic              adv;
  logic [ROW_W:0]    rd_sum;
  logic [ROW_W:0]    rd_sum_wrap;
  logic [ROW_W-1:0]  rd_phys;

  function automatic logic [ROW_W-1:0] ring_inc(input logic [ROW_W-1:0] x);
    ring_inc = (x == ROW_W'(ROWS - 1)) ? '0 : x + 1'b1;
  endfunction

  assign col_inc = FILL_W'(col_r) + 1'b1;

  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    phys_nxt   = phys_r;
    top_nxt    = top_r;
    scroll_nxt = 1'b0;
    adv        = 1'b0;
    if (op.put_char) begin
      if (col_inc == FILL_W'(COLUMNS)) begin
        col_nxt = '0;
        adv     = 1'b1;
      end else begin
        col_nxt = COL_W'(col_inc);
      end
    end
    if (op.new_line) begin
      col_nxt = '0;
      adv     = 1'b1;
    end
    if (adv) begin
      if (row_r == ROW_W'(ROWS - 1)) begin
        // scroll: old top row becomes the blank bottom row
        scroll_nxt = 1'b1;
        top_nxt    = ring_inc(top_r);
        phys_nxt   = top_r;
      end else begin
        row_nxt  = row_r + 1'b1;
        phys_nxt = ring_inc(phys_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      phys_r <= '0;
      top_r  <= '0;
      for (int i = 0; i < ROWS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      phys_r <= phys_nxt;
      top_r  <= top_nxt;
      if (op.put_char) begin
        fill_r[phys_r] <= col_inc;
      end
      if (scroll_nxt) begin
        fill_r[top_r] <= '0;
      end
    end
  end

  assign wr_addr = ADDR_W'(int'(phys_r) * COLUMNS + int'(col_r));

  // Map the requested screen row onto the ring
  assign rd_sum      = (ROW_W+1)'(rd_row) + (ROW_W+1)'(top_r);
  assign rd_sum_wrap = rd_sum - (ROW_W+1)'(ROWS);
  assign rd_phys     = (rd_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rd_sum_wrap) : ROW_W'(rd_sum);
  assign rd_addr     = ADDR_W'(int'(rd_phys) * COLUMNS + int'(rd_col));
  assign rd_hit      = rd_in_range && (FILL_W'(rd_col) < fill_r[rd_phys]);

  assign cur_row = row_r;
  assign cur_col = col_r;

endmodule

// File: src/text_console_writer.sv
// Results: a write, newline or backspace beat yields its result in the cycle after
//   acceptance; a read beat waits in ST_READ for the screen RAM data, then yields it.
// Throughput: one write per cycle if the output drains; reads block input in ST_READ.
// Scrolls move no cell data: rows form a ring with a top-row pointer.
// Reset: synchronous, active low; cursor to 0,0 and every row reads blank at once
//   through per-row fill counts, so no clearing pass follows reset.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_color,
  input  logic [4:0]                    in_read_row,
  input  logic [6:0]                    in_read_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::CELL_W-1:0]    out_read_data,
  output logic [tcw_pkg::OUT_ROW_W-1:0] out_cursor_row,
  output logic [tcw_pkg::OUT_COL_W-1:0] out_cursor_col,
  output logic                          out_scrolled
);

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                          state_r;
  logic                          accept;
  logic                          is_read;
  tcw_pkg::cur_op_t              op;
  logic                          rd_in_range;
  logic [ADDR_W-1:0]             rd_addr, wr_addr;
  logic                          rd_hit, hit_r;
  logic [tcw_pkg::CELL_W-1:0]    ram_rdata;
  logic [ROW_W-1:0]              cur_row, row_nxt;
  logic [COL_W-1:0]              cur_col, col_nxt;
  logic                          scroll_nxt;

  logic                          out_valid_r;
  logic [tcw_pkg::CELL_W-1:0]    out_data_r;
  logic [tcw_pkg::OUT_ROW_W-1:0] out_row_r;
  logic [tcw_pkg::OUT_COL_W-1:0] out_col_r;
  logic                          out_scrolled_r;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_read  = (in_cmd == tcw_pkg::CMD_READ);

  assign op.put_char = accept && !is_read && (in_char_code != tcw_pkg::CH_NEWLINE)
                       && (in_char_code != tcw_pkg::CH_BACKSPACE);
  assign op.new_line = accept && !is_read && (in_char_code == tcw_pkg::CH_NEWLINE);

  assign rd_in_range = (int'(in_read_row) < ROWS) && (int'(in_read_col) < COLUMNS);

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ROW_W   (ROW_W),
    .COL_W   (COL_W),
    .ADDR_W  (ADDR_W)
  ) u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .op          (op),
    .rd_row      (ROW_W'(in_read_row)),
    .rd_col      (COL_W'(in_read_col)),
    .rd_in_range (rd_in_range),
    .rd_addr     (rd_addr),
    .rd_hit      (rd_hit),
    .wr_addr     (wr_addr),
    .cur_row     (cur_row),
    .cur_col     (cur_col),
    .row_nxt     (row_nxt),
    .col_nxt     (col_nxt),
    .scroll_nxt  (scroll_nxt)
  );

  tcw_screen_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (op.put_char),
    .waddr (wr_addr),
    .wdata ({in_color, in_char_code}),
    .re    (accept && is_read),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && is_read) begin
            state_r     <= ST_READ;
            out_valid_r <= 1'b0;
          end else if (accept) begin
            out_valid_r <= 1'b1;
          end else if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_READ: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r <= rd_hit;
    end
    if (accept && !is_read) begin
      out_data_r     <= '0;
      out_row_r      <= tcw_pkg::OUT_ROW_W'(row_nxt);
      out_col_r      <= tcw_pkg::OUT_COL_W'(col_nxt);
      out_scrolled_r <= scroll_nxt;
    end else if (state_r == ST_READ) begin
      // drop cells past the row's fill count or outside the screen
      out_data_r     <= hit_r ? ram_rdata : '0;
      out_row_r      <= tcw_pkg::OUT_ROW_W'(cur_row);
      out_col_r      <= tcw_pkg::OUT_COL_W'(cur_col);
      out_scrolled_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scrolled_r;

  a_read_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (!out_valid_r && !in_ready))
    else $error("read pending while result slot busy or input open");

  a_read_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_read) |=> (state_r == ST_READ))
    else $error("read beat did not wait for RAM data");

  a_scroll_on_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scrolled_r) |-> (cur_row == ROW_W'(ROWS - 1)))
    else $error("scroll reported with cursor off the bottom row");

  a_write_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_read) |=> out_valid_r)
    else $error("write beat produced no result");

endmodule

// File: dv/testbench.sv
module testbench;

  localparam int         CHAR_W       = tcw_pkg::CHAR_W;
  localparam int         CELL_W       = tcw_pkg::CELL_W;
  localparam int         OUT_ROW_W    = tcw_pkg::OUT_ROW_W;
  localparam int         OUT_COL_W    = tcw_pkg::OUT_COL_W;
  localparam logic       CMD_WRITE    = tcw_pkg::CMD_WRITE;
  localparam logic       CMD_READ     = tcw_pkg::CMD_READ;
  localparam logic [7:0] CH_NEWLINE   = tcw_pkg::CH_NEWLINE;
  localparam logic [7:0] CH_BACKSPACE = tcw_pkg::CH_BACKSPACE;

  localparam int COLS        = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS        = tcw_pkg::ROWS_DEF;
  localparam int BEAT_TARGET = 1850;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic                cmd;
    logic [CHAR_W-1:0]   char_code;
    logic [CHAR_W-1:0]   color;
    logic [4:0]          read_row;
    logic [6:0]          read_col;
  } console_beat_t;

  typedef struct packed {
    logic [CELL_W-1:0]    read_data;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
    logic                 scrolled;
  } cursor_report_t;

  typedef struct {
    console_beat_t  beat;
    bit             typed;
    cursor_report_t report;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_WRITE;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic [CHAR_W-1:0]    in_color = '0;
  logic [4:0]           in_read_row = '0;
  logic [6:0]           in_read_col = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    out_read_data;
  logic [OUT_ROW_W-1:0] out_cursor_row;
  logic [OUT_COL_W-1:0] out_cursor_col;
  logic                 out_scrolled;

  text_console_writer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_char_code   (in_char_code),
    .in_color       (in_color),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Screen mirror and cursor
  logic [CELL_W-1:0] screen_mirror [ROWS*COLS];
  int unsigned       cursor_r;
  int unsigned       cursor_c;

  cursor_report_t    reports_due [$];
  directed_row_t     directed_rows [$];
  cursor_report_t    want_report;

  int beats_sent;
  int useful_beats;
  int reads_sent;
  int scroll_count;
  int wrap_count;
  int mismatches;
  int reports_checked = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic logic step_row();
    cursor_r++;
    if (cursor_r >= ROWS) begin
      for (int i = 0; i < (ROWS-1)*COLS; i++) screen_mirror[i] = screen_mirror[i+COLS];
      for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) screen_mirror[i] = '0;
      cursor_r = ROWS-1;
      scroll_count++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cursor_report_t apply_console_beat(console_beat_t b);
    cursor_report_t r;
    r = '0;
    if (b.cmd == CMD_READ) begin
      if (b.read_row < ROWS && b.read_col < COLS)
        r.read_data = screen_mirror[b.read_row*COLS + b.read_col];
    end else if (b.char_code == CH_NEWLINE) begin
      cursor_c = 0;
      r.scrolled = step_row();
    end else if (b.char_code != CH_BACKSPACE) begin
      screen_mirror[cursor_r*COLS + cursor_c] = {b.color, b.char_code};
      cursor_c++;
      if (cursor_c >= COLS) begin
        cursor_c = 0;
        wrap_count++;
        r.scrolled = step_row();
      end
    end
    r.cursor_row = cursor_r[OUT_ROW_W-1:0];
    r.cursor_col = cursor_c[OUT_COL_W-1:0];
    return r;
  endfunction

  function automatic void add_row(logic cmd, logic [7:0] ch, logic [7:0] color,
                                  logic [4:0] rrow, logic [6:0] rcol, bit typed,
                                  logic [15:0] data, logic [4:0] crow, logic [6:0] ccol,
                                  logic scr);
    directed_row_t d;
    d.beat   = '{cmd, ch, color, rrow, rcol};
    d.typed  = typed;
    d.report = '{data, crow, ccol, scr};
    directed_rows.push_back(d);
  endfunction

  task automatic send_beat(input console_beat_t b, input bit typed,
                           input cursor_report_t typed_report);
    cursor_report_t predicted;
    // randomly idle the sender except inside the calm window
    while (!(beats_sent >= 400 && beats_sent < 700) && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= b.cmd;
    in_char_code <= b.char_code;
    in_color     <= b.color;
    in_read_row  <= b.read_row;
    in_read_col  <= b.read_col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_console_beat(b);
    reports_due.push_back(typed ? typed_report : predicted);
    beats_sent++;
    if (b.cmd == CMD_READ) reads_sent++;
    if (!(b.cmd == CMD_WRITE && b.char_code == CH_BACKSPACE)) useful_beats++;
  endtask

  // Receiver: random stalls, a calm window, and one long hold-off to back up the block
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && reports_checked >= 1100) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (reports_checked >= 400 && reports_checked < 700) ||
                   ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (reports_due.size() == 0) begin
        $error("report with nothing pending: data %0h row %0d col %0d scrolled %0b",
               out_read_data, out_cursor_row, out_cursor_col, out_scrolled);
        mismatches++;
      end else begin
        want_report = reports_due.pop_front();
        if (out_read_data !== want_report.read_data) begin
          $error("read_data: expected %0h, got %0h", want_report.read_data, out_read_data);
          mismatches++;
        end
        if (out_cursor_row !== want_report.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want_report.cursor_row, out_cursor_row);
          mismatches++;
        end
        if (out_cursor_col !== want_report.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want_report.cursor_col, out_cursor_col);
          mismatches++;
        end
        if (out_scrolled !== want_report.scrolled) begin
          $error("scrolled: expected %0b, got %0b", want_report.scrolled, out_scrolled);
          mismatches++;
        end
      end
      reports_checked <= reports_checked + 1;
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    console_beat_t b;
    int            line_len;
    int            pick;

    for (int i = 0; i < ROWS*COLS; i++) screen_mirror[i] = '0;
    cursor_r     = 0;
    cursor_c     = 0;
    beats_sent   = 0;
    useful_beats = 0;
    reads_sent   = 0;
    scroll_count = 0;
    wrap_count   = 0;
    mismatches   = 0;

    // blank screen, range edges, backspace, extremes of char and color, newline
    add_row(CMD_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1, 16'h0000, 5'd0, 7'd0, 1'b0);
    add_row(CMD_READ,  8'h00, 8'h00, 5'd24, 7'd79,  1, 16'h0000, 5'd0, 7'd0, 1'b0);
    add_row(CMD_READ,  8'hff, 8'hff, 5'd25, 7'd80,  1, 16'h0000, 5'd0, 7'd0, 1'b0);
    add_row(CMD_READ,  8'h00, 8'h00, 5'd31, 7'd127, 1, 16'h0000, 5'd0, 7'd0, 1'b0);
    add_row(CMD_WRITE, CH_BACKSPACE, 8'hff, 5'd0, 7'd0, 1, 16'h0000, 5'd0, 7'd0, 1'b0);
    add_row(CMD_WRITE, 8'h41, 8'h1f, 5'd0,  7'd0,   1, 16'h0000, 5'd0, 7'd1, 1'b0);
    add_row(CMD_WRITE, 8'hff, 8'hff, 5'd31, 7'd127, 1, 16'h0000, 5'd0, 7'd2, 1'b0);
    add_row(CMD_WRITE, 8'h00, 8'h00, 5'd0,  7'd0,   1, 16'h0000, 5'd0, 7'd3, 1'b0);
    add_row(CMD_READ,  8'h00, 8'h00, 5'd0,  7'd1,   1, 16'hffff, 5'd0, 7'd3, 1'b0);
    add_row(CMD_READ,  8'h00, 8'h00, 5'd0,  7'd0,   1, 16'h1f41, 5'd0, 7'd3, 1'b0);
    add_row(CMD_READ,  8'h00, 8'h00, 5'd0,  7'd2,   1, 16'h0000, 5'd0, 7'd3, 1'b0);
    add_row(CMD_WRITE, CH_NEWLINE, 8'haa, 5'd0, 7'd0, 1, 16'h0000, 5'd1, 7'd0, 1'b0);
    add_row(CMD_WRITE, CH_BACKSPACE, 8'h00, 5'd0, 7'd0, 1, 16'h0000, 5'd1, 7'd0, 1'b0);
    add_row(CMD_WRITE, 8'h7a, 8'h80, 5'd31, 7'd127, 0, '0, '0, '0, 1'b0);
    add_row(CMD_WRITE, 8'h7f, 8'h01, 5'd0,  7'd0,   0, '0, '0, '0, 1'b0);
    add_row(CMD_WRITE, CH_NEWLINE, 8'h00, 5'd0, 7'd0, 0, '0, '0, '0, 1'b0);
    add_row(CMD_READ,  8'h00, 8'h00, 5'd1,  7'd0,   0, '0, '0, '0, 1'b0);
    add_row(CMD_READ,  8'h00, 8'h00, 5'd1,  7'd1,   0, '0, '0, '0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].report);

    // Lines of text: mostly short, some long enough to wrap, ended by a newline
    while (useful_beats < BEAT_TARGET) begin
      line_len = ($urandom_range(99) < 60) ? $urandom_range(20) : $urandom_range(90, 70);
      for (int k = 0; k < line_len && useful_beats < BEAT_TARGET; k++) begin
        b.char_code = CHAR_W'($urandom);
        b.color     = CHAR_W'($urandom);
        b.read_row  = 5'($urandom);
        b.read_col  = 7'($urandom);
        pick        = $urandom_range(99);
        if (pick < 15) begin
          b.cmd = CMD_READ;
          if (pick < 13) begin
            b.read_row = 5'($urandom_range(ROWS-1));
            b.read_col = 7'($urandom_range(COLS-1));
          end
        end else begin
          b.cmd = CMD_WRITE;
          if (pick < 18) b.char_code = CH_BACKSPACE;
        end
        send_beat(b, 1'b0, '0);
      end
      if (useful_beats < BEAT_TARGET) begin
        b.cmd       = CMD_WRITE;
        b.char_code = CH_NEWLINE;
        b.color     = CHAR_W'($urandom);
        b.read_row  = 5'($urandom);
        b.read_col  = 7'($urandom);
        send_beat(b, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d beats (%0d reads) and checked %0d reports.",
             beats_sent, reads_sent, reports_checked);
    $display("Cursor wrapped at line end %0d times; screen scrolled %0d times.",
             wrap_count, scroll_count);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
